// ===== rtl/pdas_pkg.sv =====
package pdas_pkg;

  localparam int unsigned MAX_ACTIVE_DEFAULT = 512;
  localparam int unsigned NUM_IDS_DEFAULT    = 512;

  localparam int unsigned ID_W    = 9;
  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned COUNT_W = 10;

  typedef enum logic {
    FUNC_ACTIVATE   = 1'b0,
    FUNC_DEACTIVATE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    STAT_ADDED      = 3'd0,
    STAT_ALREADY    = 3'd1,
    STAT_INELIGIBLE = 3'd2,
    STAT_NEEDS_ROOT = 3'd3,
    STAT_FULL       = 3'd4,
    STAT_REMOVED    = 3'd5,
    STAT_NOT_ACTIVE = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_APPEND_POOL,
    S_MOVE_FLAT,
    S_MOVE_POOL,
    S_RETIRE
  } state_e;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   call_id;
    logic              ineligible;
    logic              root_only;
    logic              is_expensive;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] active_count;
    logic [COUNT_W-1:0] cheap_count;
    logic [COUNT_W-1:0] expensive_count;
  } out_item_t;

endpackage

// ===== rtl/partitioned_dense_active_set.sv =====
// Steps: the item's back-index entry is read; a refused activate or unknown deactivate is then
// answered; an add appends to the flat, then the pool list; a removal moves the last flat and
// then the last pool entry, if any, and retires. A new item waits until the result is sent.
// Reset: asynchronous, active low; a clearing pass then zeroes the back-index memory, during
// which no input item is taken (configuration writes still land).
module partitioned_dense_active_set_core
  import pdas_pkg::*;
#(
  parameter int unsigned MAX_ACTIVE = MAX_ACTIVE_DEFAULT,
  parameter int unsigned NUM_IDS    = NUM_IDS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // Configuration: running_as_root
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  // Input item channel
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  // Result channel
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int unsigned CW = $clog2(MAX_ACTIVE + 1);
  localparam int unsigned IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

  // Back-index entry: position plus one in each list, zero when inactive.
  typedef struct packed {
    logic [CW-1:0] flat_bi;
    logic [CW-1:0] pool_bi;
  } bi_entry_t;

  // List entry: one identifier per list at the same position.
  typedef struct packed {
    logic [ID_W-1:0] flat;
    logic [ID_W-1:0] cheap;
    logic [ID_W-1:0] expensive;
  } list_entry_t;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  // Back-index memory, addressed by identifier.
  bi_entry_t   bim_mem [NUM_IDS];
  bi_entry_t   bim_rd_q;
  logic        bim_re;
  logic [IW-1:0] bim_raddr;
  logic        bim_we_flat, bim_we_pool;
  logic [IW-1:0] bim_waddr;
  bi_entry_t   bim_wdata;

  // List memory, addressed by position; each list is a field with its own write enable.
  list_entry_t lm_mem [MAX_ACTIVE];
  list_entry_t lm_rd_q;
  logic        lm_re;
  logic [AW-1:0] lm_raddr;
  logic        lm_we_flat, lm_we_cheap, lm_we_exp;
  logic [AW-1:0] lm_waddr_flat, lm_waddr_pool;
  logic [ID_W-1:0] lm_wid_flat, lm_wid_pool;

  always_ff @(posedge clk_i) begin
    if (bim_we_flat) begin
      bim_mem[bim_waddr].flat_bi <= bim_wdata.flat_bi;
    end
    if (bim_we_pool) begin
      bim_mem[bim_waddr].pool_bi <= bim_wdata.pool_bi;
    end
    if (bim_re) begin
      bim_rd_q <= bim_mem[bim_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lm_we_flat) begin
      lm_mem[lm_waddr_flat].flat <= lm_wid_flat;
    end
    if (lm_we_cheap) begin
      lm_mem[lm_waddr_pool].cheap <= lm_wid_pool;
    end
    if (lm_we_exp) begin
      lm_mem[lm_waddr_pool].expensive <= lm_wid_pool;
    end
    if (lm_re) begin
      lm_rd_q <= lm_mem[lm_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and counter registers
  // ---------------------------------------------------------------------------
  state_e        state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  in_item_t      item_q, item_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] fcnt_q, fcnt_d;
  logic [CW-1:0] ccnt_q, ccnt_d;
  logic [CW-1:0] ecnt_q, ecnt_d;
  logic          root_q, root_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          in_xfer;
  logic          out_free;
  logic          res_fire;
  out_item_t     res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Decode of the looked-up entry
  // ---------------------------------------------------------------------------
  logic          id_ok;
  logic [CW-1:0] pcnt;
  logic [CW-1:0] fbi_m1, pbi_m1;
  logic [CW-1:0] flast, plast;
  logic [CW-1:0] fpos, ppos;
  logic          do_pool;
  logic [ID_W-1:0] moved_flat, moved_pool;
  logic          moved_flat_ok, moved_pool_ok;
  logic          refuse;
  status_e       refuse_stat;

  always_comb begin
    id_ok  = int'(item_q.call_id) < NUM_IDS;
    pcnt   = item_q.is_expensive ? ecnt_q : ccnt_q;
    fbi_m1 = bim_rd_q.flat_bi - 1'b1;
    pbi_m1 = bim_rd_q.pool_bi - 1'b1;
    flast  = fcnt_q - 1'b1;
    plast  = pcnt - 1'b1;
    // Clamp a stale position into the live part of the list.
    fpos   = (fbi_m1 >= fcnt_q) ? flast : fbi_m1;
    ppos   = (pbi_m1 >= pcnt) ? plast : pbi_m1;
    do_pool = (bim_rd_q.pool_bi != '0) && (pcnt != '0);
    moved_flat    = lm_rd_q.flat;
    moved_pool    = item_q.is_expensive ? lm_rd_q.expensive : lm_rd_q.cheap;
    moved_flat_ok = int'(moved_flat) < NUM_IDS;
    moved_pool_ok = int'(moved_pool) < NUM_IDS;

    refuse      = 1'b1;
    refuse_stat = STAT_NOT_ACTIVE;
    if (item_q.func == FUNC_ACTIVATE) begin
      priority if (item_q.ineligible || !id_ok) begin
        refuse_stat = STAT_INELIGIBLE;
      end else if (item_q.root_only && !root_q) begin
        refuse_stat = STAT_NEEDS_ROOT;
      end else if (bim_rd_q.flat_bi != '0) begin
        refuse_stat = STAT_ALREADY;
      end else if (int'(fcnt_q) >= MAX_ACTIVE || int'(pcnt) >= MAX_ACTIVE) begin
        refuse_stat = STAT_FULL;
      end else begin
        refuse = 1'b0;
      end
    end else begin
      refuse = !id_ok || (bim_rd_q.flat_bi == '0) || (fcnt_q == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (int'(clr_q) == NUM_IDS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (refuse) begin
          if (out_free) begin
            state_d = S_IDLE;
          end
        end else if (item_q.func == FUNC_ACTIVATE) begin
          state_d = S_APPEND_POOL;
        end else begin
          state_d = S_MOVE_FLAT;
        end
      end
      S_APPEND_POOL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_MOVE_FLAT: begin
        state_d = do_pool ? S_MOVE_POOL : S_RETIRE;
      end
      S_MOVE_POOL: begin
        state_d = S_RETIRE;
      end
      S_RETIRE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath, memory controls and result
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_d  = clr_q;
    item_d = item_q;
    pos_d  = pos_q;
    fcnt_d = fcnt_q;
    ccnt_d = ccnt_q;
    ecnt_d = ecnt_q;
    root_d = cfg_valid_i ? cfg_data_i : root_q;

    bim_re      = in_xfer;
    bim_raddr   = IW'(in_data_i.call_id);
    bim_we_flat = 1'b0;
    bim_we_pool = 1'b0;
    bim_waddr   = IW'(item_q.call_id);
    bim_wdata   = '0;

    lm_re         = 1'b0;
    lm_raddr      = AW'(flast);
    lm_we_flat    = 1'b0;
    lm_we_cheap   = 1'b0;
    lm_we_exp     = 1'b0;
    lm_waddr_flat = AW'(fcnt_q);
    lm_waddr_pool = AW'(pcnt);
    lm_wid_flat   = item_q.call_id;
    lm_wid_pool   = item_q.call_id;

    res_fire = 1'b0;
    res      = '0;
    res.active_count    = COUNT_W'(fcnt_q);
    res.cheap_count     = COUNT_W'(ccnt_q);
    res.expensive_count = COUNT_W'(ecnt_q);

    if (in_xfer) begin
      item_d = in_data_i;
    end

    unique case (state_q)
      S_CLEAR: begin
        // Sweep the back-index memory to all inactive.
        bim_we_flat = 1'b1;
        bim_we_pool = 1'b1;
        bim_waddr   = clr_q;
        clr_d       = clr_q + 1'b1;
      end
      S_IDLE: begin
      end
      S_LOOKUP: begin
        if (refuse) begin
          res.status = refuse_stat;
          res_fire   = out_free;
        end else if (item_q.func == FUNC_ACTIVATE) begin
          // Append to the flat list and record both back-indices.
          lm_we_flat        = 1'b1;
          bim_we_flat       = 1'b1;
          bim_we_pool       = 1'b1;
          bim_wdata.flat_bi = fcnt_q + 1'b1;
          bim_wdata.pool_bi = pcnt + 1'b1;
        end else begin
          // Fetch the last flat entry for the swap.
          pos_d    = AW'(fpos);
          lm_re    = 1'b1;
          lm_raddr = AW'(flast);
        end
      end
      S_APPEND_POOL: begin
        lm_we_cheap = !item_q.is_expensive;
        lm_we_exp   = item_q.is_expensive;
        res.status  = STAT_ADDED;
        res.slot    = SLOT_W'(fcnt_q);
        res.active_count = COUNT_W'(fcnt_q + 1'b1);
        if (item_q.is_expensive) begin
          res.expensive_count = COUNT_W'(ecnt_q + 1'b1);
        end else begin
          res.cheap_count = COUNT_W'(ccnt_q + 1'b1);
        end
        res_fire = out_free;
        if (out_free) begin
          fcnt_d = fcnt_q + 1'b1;
          if (item_q.is_expensive) begin
            ecnt_d = ecnt_q + 1'b1;
          end else begin
            ccnt_d = ccnt_q + 1'b1;
          end
        end
      end
      S_MOVE_FLAT: begin
        // Move the last flat entry into the vacated slot and fix its back-index.
        if (pos_q != AW'(flast)) begin
          lm_we_flat        = 1'b1;
          lm_waddr_flat     = pos_q;
          lm_wid_flat       = moved_flat;
          bim_we_flat       = moved_flat_ok;
          bim_waddr         = IW'(moved_flat);
          bim_wdata.flat_bi = CW'(pos_q) + 1'b1;
        end
        fcnt_d   = flast;
        // Fetch the last pool entry for the second swap.
        lm_re    = do_pool;
        lm_raddr = AW'(plast);
      end
      S_MOVE_POOL: begin
        if (ppos != plast) begin
          lm_we_cheap       = !item_q.is_expensive;
          lm_we_exp         = item_q.is_expensive;
          lm_waddr_pool     = AW'(ppos);
          lm_wid_pool       = moved_pool;
          bim_we_pool       = moved_pool_ok;
          bim_waddr         = IW'(moved_pool);
          bim_wdata.pool_bi = ppos + 1'b1;
        end
        if (item_q.is_expensive) begin
          ecnt_d = plast;
        end else begin
          ccnt_d = plast;
        end
      end
      S_RETIRE: begin
        // Mark the identifier inactive in both lists; this write comes last.
        bim_we_flat = 1'b1;
        bim_we_pool = 1'b1;
        res.status  = STAT_REMOVED;
        res.slot    = SLOT_W'(pos_q);
        res_fire    = out_free;
      end
      default: begin
      end
    endcase

    out_d       = res_fire ? res : out_q;
    out_valid_d = res_fire ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      fcnt_q      <= '0;
      ccnt_q      <= '0;
      ecnt_q      <= '0;
      root_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fcnt_q      <= fcnt_d;
      ccnt_q      <= ccnt_d;
      ecnt_q      <= ecnt_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pos_q  <= pos_d;
    out_q  <= out_d;
  end

endmodule
